### hw/rtl/par_pkg.sv
// Shared types, constants and the arctangent table for the polar angle and radius unit.
`default_nettype none
package par_pkg;

    localparam int ITERATIONS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TABLE_LEN       = 24;

    localparam int IN_W     = 16;
    localparam int MAG_W    = 16;
    localparam int ANGLE_W  = 15;
    localparam int RADIUS_W = 17;

    localparam int VEC_SHIFT = 24;
    localparam int VW        = MAG_W + VEC_SHIFT + 3;
    localparam int ZW        = 31;
    localparam int DEG_SHIFT = 22;
    localparam int AW        = 34;
    localparam int TW        = 17;
    localparam int RND_SHIFT = 16;

    localparam int SQRT_STEPS = 17;
    localparam int RW         = 34;
    localparam int SQ_W       = 2 * MAG_W;

    localparam logic [0:0] REG_CENTRE_CHROMA    = 1'b0;
    localparam logic [0:0] REG_CENTRE_LIGHTNESS = 1'b1;

    typedef logic [3:0] t_cls;
    localparam t_cls CLS_ZERO  = 4'd0;
    localparam t_cls CLS_POS_X = 4'd1;
    localparam t_cls CLS_NEG_X = 4'd2;
    localparam t_cls CLS_POS_Y = 4'd3;
    localparam t_cls CLS_NEG_Y = 4'd4;
    localparam t_cls CLS_Q1    = 4'd5;
    localparam t_cls CLS_Q2    = 4'd6;
    localparam t_cls CLS_Q3    = 4'd7;
    localparam t_cls CLS_Q4    = 4'd8;

    localparam logic [TW-1:0] ANGLE_UNITS   = TW'(23040);
    localparam logic [TW-1:0] ANGLE_UNITS_2 = TW'(46080);
    localparam logic [ANGLE_W-1:0] ANGLE_0   = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] ANGLE_90  = ANGLE_W'(90 * 64);
    localparam logic [ANGLE_W-1:0] ANGLE_180 = ANGLE_W'(180 * 64);
    localparam logic [ANGLE_W-1:0] ANGLE_270 = ANGLE_W'(270 * 64);

    localparam logic signed [AW-1:0] FULL_CIRCLE = AW'(360) << DEG_SHIFT;
    localparam logic signed [AW-1:0] HALF_CIRCLE = AW'(180) << DEG_SHIFT;
    localparam logic signed [AW-1:0] HALF_UNIT   = AW'(1) << (RND_SHIFT - 1);

    localparam logic [27:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
        28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
        28'd938729,    28'd469366,    28'd234683,   28'd117342,
        28'd58671,     28'd29335,     28'd14668,    28'd7334,
        28'd3667,      28'd1833,      28'd917,      28'd458,
        28'd229,       28'd115,       28'd57,       28'd29
    };

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        t_cls             cls;
    } t_item;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RW-1:0]        s;
        logic [RW-1:0]        r;
        t_cls                 cls;
    } t_stg;

endpackage
`default_nettype wire

### hw/rtl/par_front.sv
// Front end: centre registers, offset, magnitude and quadrant classification.
`default_nettype none
module par_front
    import par_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_addr,
    input  wire logic [IN_W-1:0]   i_cfg_wdata,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_chroma,
    input  wire logic [IN_W-1:0]   i_lightness,
    output logic                   o_stall,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_item                  o_item
);

    logic [IN_W-1:0] r_centre_c;
    logic [IN_W-1:0] r_centre_l;
    logic signed [IN_W:0] dx;
    logic signed [IN_W:0] dy;
    logic [IN_W:0] abs_x;
    logic [IN_W:0] abs_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_c <= '0;
            r_centre_l <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CENTRE_CHROMA:    r_centre_c <= i_cfg_wdata;
                REG_CENTRE_LIGHTNESS: r_centre_l <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx = $signed({i_chroma[IN_W-1], i_chroma}) - $signed({r_centre_c[IN_W-1], r_centre_c});
        dy = $signed({i_lightness[IN_W-1], i_lightness})
           - $signed({r_centre_l[IN_W-1], r_centre_l});
        abs_x = dx[IN_W] ? (IN_W+1)'(-dx) : dx;
        abs_y = dy[IN_W] ? (IN_W+1)'(-dy) : dy;
        o_item.ax = abs_x[MAG_W-1:0];
        o_item.ay = abs_y[MAG_W-1:0];
        if (dx == '0 && dy == '0) begin
            o_item.cls = CLS_ZERO;
        end else if (dx == '0) begin
            o_item.cls = dy[IN_W] ? CLS_NEG_Y : CLS_POS_Y;
        end else if (dy == '0) begin
            o_item.cls = dx[IN_W] ? CLS_NEG_X : CLS_POS_X;
        end else if (!dx[IN_W]) begin
            o_item.cls = dy[IN_W] ? CLS_Q4 : CLS_Q1;
        end else begin
            o_item.cls = dy[IN_W] ? CLS_Q3 : CLS_Q2;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

### hw/rtl/par_queue.sv
// Small register queue between the front end and the compute pipeline.
`default_nettype none
module par_queue #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty) else $error("queue lost a request");
`endif

endmodule
`default_nettype wire

### hw/rtl/par_back.sv
// Compute pipeline: CORDIC vectoring, digit-by-digit square root, angle folding, output register.
`default_nettype none
module par_back
    import par_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_item               i_item,
    input  wire logic                i_empty,
    output logic                     o_pop,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output logic [ANGLE_W-1:0]       o_angle,
    output logic [RADIUS_W-1:0]      o_radius
);

    localparam int NSTG = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

    logic adv;

    logic             r_a_vld;
    logic [MAG_W-1:0] r_a_ax;
    logic [MAG_W-1:0] r_a_ay;
    logic [SQ_W-1:0]  r_a_sqx;
    logic [SQ_W-1:0]  r_a_sqy;
    t_cls             r_a_cls;

    logic [NSTG:0] r_vld;
    t_stg          r_pipe [0:NSTG];
    t_stg          n_pipe [0:NSTG];

    logic                 r_f_vld;
    logic [TW-1:0]        r_f_t;
    logic [RADIUS_W-1:0]  r_f_rad;
    t_cls                 r_f_cls;

    logic signed [AW-1:0] fold_base;
    logic signed [AW-1:0] fold_z;
    logic signed [AW-1:0] fold_sum;
    logic [TW-1:0]        n_f_t;
    logic [RADIUS_W-1:0]  n_f_rad;

    logic                 r_out_valid;
    logic [ANGLE_W-1:0]   r_angle;
    logic [RADIUS_W-1:0]  r_radius;
    logic [ANGLE_W-1:0]   n_angle;
    logic [TW-1:0]        wrapped;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ax  <= i_item.ax;
            r_a_ay  <= i_item.ay;
            r_a_sqx <= i_item.ax * i_item.ax;
            r_a_sqy <= i_item.ay * i_item.ay;
            r_a_cls <= i_item.cls;
        end
    end

    always_comb begin
        n_pipe[0].x   = VW'({r_a_ax, VEC_SHIFT'(0)});
        n_pipe[0].y   = VW'({r_a_ay, VEC_SHIFT'(0)});
        n_pipe[0].z   = '0;
        n_pipe[0].s   = RW'(r_a_sqx) + RW'(r_a_sqy);
        n_pipe[0].r   = '0;
        n_pipe[0].cls = r_a_cls;
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam bit DO_ROT  = (k < ITERATIONS);
        localparam bit DO_SQRT = (k < SQRT_STEPS);
        localparam int SH      = DO_SQRT ? 2 * (SQRT_STEPS - 1 - k) : 0;
        localparam int TI      = (k < TABLE_LEN) ? k : 0;

        always_comb begin
            logic signed [VW-1:0] x;
            logic signed [VW-1:0] y;
            logic signed [VW-1:0] xs;
            logic signed [VW-1:0] ys;
            logic signed [ZW-1:0] tab;
            logic [RW-1:0]        bitv;
            logic [RW-1:0]        rb;
            x    = r_pipe[k].x;
            y    = r_pipe[k].y;
            xs   = x >>> k;
            ys   = y >>> k;
            tab  = ZW'(ATAN_TAB[TI]);
            bitv = RW'(1) << SH;
            rb   = r_pipe[k].r + bitv;
            n_pipe[k+1] = r_pipe[k];
            if (DO_ROT) begin
                if (!y[VW-1]) begin
                    n_pipe[k+1].x = x + ys;
                    n_pipe[k+1].y = y - xs;
                    n_pipe[k+1].z = r_pipe[k].z + tab;
                end else begin
                    n_pipe[k+1].x = x - ys;
                    n_pipe[k+1].y = y + xs;
                    n_pipe[k+1].z = r_pipe[k].z - tab;
                end
            end
            if (DO_SQRT) begin
                if (r_pipe[k].s >= rb) begin
                    n_pipe[k+1].s = r_pipe[k].s - rb;
                    n_pipe[k+1].r = (r_pipe[k].r >> 1) + bitv;
                end else begin
                    n_pipe[k+1].r = r_pipe[k].r >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j <= NSTG; j++) begin
                r_pipe[j] <= n_pipe[j];
            end
        end
    end

    always_comb begin
        fold_z = AW'(r_pipe[NSTG].z);
        case (r_pipe[NSTG].cls)
            CLS_Q1:  fold_base = FULL_CIRCLE + HALF_UNIT;
            CLS_Q2:  fold_base = FULL_CIRCLE + HALF_CIRCLE + HALF_UNIT;
            CLS_Q3:  fold_base = FULL_CIRCLE + HALF_CIRCLE + HALF_UNIT;
            CLS_Q4:  fold_base = FULL_CIRCLE + FULL_CIRCLE + HALF_UNIT;
            default: fold_base = FULL_CIRCLE + HALF_UNIT;
        endcase
        if (r_pipe[NSTG].cls == CLS_Q2 || r_pipe[NSTG].cls == CLS_Q4) begin
            fold_sum = fold_base - fold_z;
        end else begin
            fold_sum = fold_base + fold_z;
        end
        n_f_t   = fold_sum[AW-1] ? '0 : fold_sum[RND_SHIFT+TW-1:RND_SHIFT];
        n_f_rad = r_pipe[NSTG].r[RADIUS_W-1:0]
                + RADIUS_W'(r_pipe[NSTG].s > r_pipe[NSTG].r);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_t   <= n_f_t;
            r_f_rad <= n_f_rad;
            r_f_cls <= r_pipe[NSTG].cls;
        end
    end

    always_comb begin
        if (r_f_t >= ANGLE_UNITS_2) begin
            wrapped = r_f_t - ANGLE_UNITS_2;
        end else if (r_f_t >= ANGLE_UNITS) begin
            wrapped = r_f_t - ANGLE_UNITS;
        end else begin
            wrapped = r_f_t;
        end
        case (r_f_cls)
            CLS_ZERO:  n_angle = ANGLE_0;
            CLS_POS_X: n_angle = ANGLE_0;
            CLS_POS_Y: n_angle = ANGLE_90;
            CLS_NEG_X: n_angle = ANGLE_180;
            CLS_NEG_Y: n_angle = ANGLE_270;
            default:   n_angle = wrapped[ANGLE_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_angle  <= n_angle;
            r_radius <= r_f_rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_vld       <= '0;
            r_f_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_vld     <= !i_empty;
            r_vld       <= {r_vld[NSTG-1:0], r_a_vld};
            r_f_vld     <= r_vld[NSTG];
            r_out_valid <= r_f_vld;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_angle  = r_angle;
    assign o_radius = r_radius;

`ifndef ASSERT_OFF
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (TW'(o_angle) < ANGLE_UNITS)) else $error("angle out of range");
`endif

endmodule
`default_nettype wire

### hw/rtl/polar_angle_and_radius_unit.sv
// Request path: queue, input register, CORDIC and square-root stages, fold and output registers.
// Throughput: one request per cycle when not stalled; one CORDIC and square-root step per stage.
// A short request queue decouples input acceptance from the compute pipeline.
// The whole compute pipeline holds while a finished result is stalled at the output.
// Reset (synchronous, active low) clears the queue, all valid bits and both centre registers.
`default_nettype none
module polar_angle_and_radius_unit
    import par_pkg::*;
#(
    parameter int ITERATIONS  = ITERATIONS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [0:0]          i_cfg_addr,
    input  wire logic [IN_W-1:0]     i_cfg_wdata,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [IN_W-1:0]     i_chroma,
    input  wire logic [IN_W-1:0]     i_lightness,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [ANGLE_W-1:0]       o_angle,
    output logic [RADIUS_W-1:0]      o_radius
);

    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_item wr_item;
    t_item rd_item;

    par_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_chroma    (i_chroma),
        .i_lightness (i_lightness),
        .o_stall     (o_stall),
        .i_full      (full),
        .o_push      (push),
        .o_item      (wr_item)
    );

    par_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     ($bits(t_item))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (rd_item),
        .o_empty (empty)
    );

    par_back #(
        .ITERATIONS (ITERATIONS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (rd_item),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_angle  (o_angle),
        .o_radius (o_radius)
    );

endmodule
`default_nettype wire

### sim/tb_polar_angle_and_radius_unit.sv
// Self-checking testbench for the polar angle and radius unit.
module tb_polar_angle_and_radius_unit
    import par_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CORDIC_STEPS   = ITERATIONS_DEF;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    TAIL_CYCLES    = 40;
    localparam int    PHASE_POINTS   = 120;
    localparam longint DEG_Q22_FULL  = longint'(360) << 22;
    localparam longint DEG_Q22_HALF  = longint'(180) << 22;
    localparam longint UNITS_PER_REV = 23040;

    localparam longint ATAN_Q22 [0:23] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    typedef struct {
        logic [ANGLE_W-1:0]  angle;
        logic [RADIUS_W-1:0] radius;
    } t_polar;

    class polar_scoreboard;
        logic signed [IN_W-1:0] centre_chroma;
        logic signed [IN_W-1:0] centre_lightness;
        t_polar pending_polar [$];
        int     requests;
        int     results;
        int     errors;

        function new();
            centre_chroma    = '0;
            centre_lightness = '0;
            requests         = 0;
            results          = 0;
            errors           = 0;
        endfunction

        function void set_centre(logic [0:0] idx, logic [IN_W-1:0] value);
            if (idx == REG_CENTRE_CHROMA) begin
                centre_chroma = value;
            end else begin
                centre_lightness = value;
            end
        endfunction

        function t_polar polar_of(logic signed [IN_W-1:0] c, logic signed [IN_W-1:0] l);
            t_polar          res;
            int              dx;
            int              dy;
            longint          ax;
            longint          ay;
            longint          x;
            longint          y;
            longint          z;
            longint          xs;
            longint          ys;
            longint          a;
            longint unsigned sq;
            longint unsigned root;
            longint unsigned bitv;
            dx = int'(c) - int'(centre_chroma);
            dy = int'(l) - int'(centre_lightness);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (dx == 0 && dy == 0) begin
                res.angle = ANGLE_0;
            end else if (dx == 0) begin
                res.angle = (dy > 0) ? ANGLE_90 : ANGLE_270;
            end else if (dy == 0) begin
                res.angle = (dx > 0) ? ANGLE_0 : ANGLE_180;
            end else begin
                x = ax <<< 24;
                y = ay <<< 24;
                z = 0;
                for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_Q22[i];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_Q22[i];
                    end
                end
                if (dx > 0 && dy > 0) begin
                    a = z;
                end else if (dx < 0 && dy > 0) begin
                    a = DEG_Q22_HALF - z;
                end else if (dx < 0) begin
                    a = DEG_Q22_HALF + z;
                end else begin
                    a = DEG_Q22_FULL - z;
                end
                a = a + DEG_Q22_FULL + (longint'(1) <<< 15);
                if (a < 0) begin
                    a = 0;
                end
                res.angle = ANGLE_W'((a >>> 16) % UNITS_PER_REV);
            end
            sq   = longint'(ax * ax + ay * ay);
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > sq) begin
                bitv = bitv >> 2;
            end
            while (bitv != 0) begin
                if (sq >= root + bitv) begin
                    sq   = sq - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            if (sq > root) begin
                root = root + 1;
            end
            res.radius = RADIUS_W'(root);
            return res;
        endfunction

        function void note_request(logic [IN_W-1:0] c, logic [IN_W-1:0] l);
            pending_polar.push_back(polar_of(c, l));
            requests++;
        endfunction

        function void check_result(logic [ANGLE_W-1:0] got_angle,
                                   logic [RADIUS_W-1:0] got_radius);
            t_polar exp_res;
            results++;
            if (pending_polar.size() == 0) begin
                errors++;
                $display("%0t: unexpected result angle %0d radius %0d",
                         $time, got_angle, got_radius);
            end else begin
                exp_res = pending_polar.pop_front();
                if (got_angle !== exp_res.angle) begin
                    errors++;
                    $display("%0t: angle mismatch expected %0d actual %0d",
                             $time, exp_res.angle, got_angle);
                end
                if (got_radius !== exp_res.radius) begin
                    errors++;
                    $display("%0t: radius mismatch expected %0d actual %0d",
                             $time, exp_res.radius, got_radius);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [0:0]          i_cfg_addr;
    logic [IN_W-1:0]     i_cfg_wdata;
    logic                i_valid;
    logic                o_stall;
    logic [IN_W-1:0]     i_chroma;
    logic [IN_W-1:0]     i_lightness;
    logic                o_valid;
    logic                i_stall;
    logic [ANGLE_W-1:0]  o_angle;
    logic [RADIUS_W-1:0] o_radius;

    polar_scoreboard sb;
    int              tx_gap_pct;
    int              rx_stall_pct;
    int              idle_cycles;
    int              settings_used;

    polar_angle_and_radius_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_chroma    (i_chroma),
        .i_lightness (i_lightness),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_angle     (o_angle),
        .o_radius    (o_radius)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // receiver back-pressure in random bursts
    initial begin : rx_side
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                n = $urandom_range(1, 4);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                sb.note_request(i_chroma, i_lightness);
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_angle, o_radius);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results still pending",
                         $time, sb.pending_polar.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic push_point(logic [IN_W-1:0] c, logic [IN_W-1:0] l);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_chroma    <= c;
        i_lightness <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_polar.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_centre(logic [0:0] idx, logic [IN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_centre(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly uniform points, plus axis hits, centre hits and near-centre offsets
    task automatic random_point(output logic [IN_W-1:0] c, output logic [IN_W-1:0] l);
        int pick;
        pick = $urandom_range(0, 99);
        c    = IN_W'($urandom);
        l    = IN_W'($urandom);
        if (pick < 60) begin
        end else if (pick < 72) begin
            c = sb.centre_chroma;
        end else if (pick < 84) begin
            l = sb.centre_lightness;
        end else if (pick < 90) begin
            c = sb.centre_chroma;
            l = sb.centre_lightness;
        end else begin
            c = sb.centre_chroma + IN_W'($urandom_range(0, 16) - 8);
            l = sb.centre_lightness + IN_W'($urandom_range(0, 16) - 8);
        end
    endtask

    int dir_c [22] = '{0, 64, -64, 0, 0, 64, -64, -64, 64, 32767, -32768,
                       32767, -32768, 1, 0, 1, -1, 32767, 1, -32768, 0, 3};
    int dir_l [22] = '{0, 0, 0, 64, -64, 64, 64, -64, -64, 32767, -32768,
                       -32768, 32767, 0, -1, 1, 1, 1, 32767, 0, -32768, -5};
    int centre_c [6]  = '{0, -1, 32767, -32768, 32767, -1};
    int centre_l [6]  = '{0, -1, 32767, -32768, -32768, -1};
    int gap_pct [6]   = '{20, 40, 0, 25, 10, 0};

    initial begin : stimulus
        logic [IN_W-1:0] pc;
        logic [IN_W-1:0] pl;
        logic [IN_W-1:0] cc;
        logic [IN_W-1:0] cl;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_CENTRE_CHROMA;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_chroma      = '0;
        i_lightness   = '0;
        tx_gap_pct    = 15;
        rx_stall_pct  = 15;
        idle_cycles   = 0;
        settings_used = 1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset centre: axes, quadrants and the corners of the input range
        for (int k = 0; k < 22; k++) begin
            push_point(IN_W'(dir_c[k]), IN_W'(dir_l[k]));
        end

        for (int ph = 0; ph < 6; ph++) begin
            drain_requests();
            if (ph == 5) begin
                rx_stall_pct = 0;
            end else begin
                rx_stall_pct = gap_pct[(ph + 2) % 6];
            end
            tx_gap_pct = gap_pct[ph];
            cc = (centre_c[ph] == -1) ? IN_W'($urandom) : IN_W'(centre_c[ph]);
            cl = (centre_l[ph] == -1) ? IN_W'($urandom) : IN_W'(centre_l[ph]);
            write_centre(REG_CENTRE_CHROMA, cc);
            write_centre(REG_CENTRE_LIGHTNESS, cl);
            settings_used++;
            push_point(16'h7fff, 16'h7fff);
            push_point(16'h8000, 16'h8000);
            push_point(16'h7fff, 16'h8000);
            push_point(16'h8000, 16'h7fff);
            for (int k = 0; k < PHASE_POINTS; k++) begin
                if (ph == 1 && k == PHASE_POINTS / 2) begin
                    drain_requests();
                end
                random_point(pc, pl);
                push_point(pc, pl);
            end
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d points against %0d results over %0d centre settings,",
                 sb.requests, sb.results, settings_used);
        $display("including axes, zero offsets, range corners and back-pressure; %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending_polar.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
